// ===== src/dnle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants of the DNS name label encoder: label store
// geometry, character codes, result status codes and the command item that
// goes from the classifying front to the emitting back.
// ----------------------------------------------------------------------------
package dnle_pkg;

	// label store geometry
	localparam int LABEL_BYTES = 32;
	localparam int IDX_W       = $clog2(LABEL_BYTES);
	localparam int ADDR_W      = IDX_W + 1;

	// byte count against the space limit, plus one bit of headroom for sums
	localparam int BYTE_CNT_W = 16;
	localparam int SUM_W      = BYTE_CNT_W + 1;

	// command queue depth (power of two)
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// body commands in flight that still hold a store bank
	localparam int BANKS    = 2;
	localparam int BCNT_W   = $clog2(BANKS + 1);

	// character codes
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_END = 8'h00;

	// length byte mask
	localparam logic [7:0] LEN_MASK = 8'h3f;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SPACE = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;

	// closing result of a command
	localparam logic [1:0] TAIL_NONE = 2'd0;
	localparam logic [1:0] TAIL_TERM = 2'd1;
	localparam logic [1:0] TAIL_ERR1 = 2'd2;
	localparam logic [1:0] TAIL_ERR2 = 2'd3;

	// work item for the back: optional length byte, optional body, closing result
	typedef struct packed {
		logic             emit_len;
		logic             emit_body;
		logic [1:0]       tail;
		logic [IDX_W-1:0] len;
		logic             bank;
	} cmd_t;

	// label store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

endpackage

// ===== src/dnle_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_cmdq
// Short command queue between the front and the back; lets the front keep
// taking characters while the back is still sending an earlier label.
// ----------------------------------------------------------------------------
module dnle_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dnle_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output dnle_pkg::cmd_t  head,
	output logic            full,
	output logic            empty
);

	dnle_pkg::cmd_t                 entry_q [dnle_pkg::QDEPTH];
	logic [dnle_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [dnle_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [dnle_pkg::QCNT_W-1:0]    cnt_q;

	assign full  = (cnt_q == dnle_pkg::QCNT_W'(dnle_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== src/dnle_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name characters, fills the label store, keeps the label length,
// the byte count of the name and the discard flag, and decides for every
// separator or end which bytes and which closing result the back must send.
// ----------------------------------------------------------------------------
module dnle_front (
	input  logic                            clk,
	input  logic                            arst_n,
	// input item channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      char_code,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dnle_pkg::BYTE_CNT_W-1:0] space_limit,
	// to the back
	output dnle_pkg::wr_t                   wr,
	output logic                            cmd_push,
	output dnle_pkg::cmd_t                  cmd,
	input  logic                            q_full,
	input  logic                            body_done
);

	logic [dnle_pkg::BYTE_CNT_W-1:0] lim_q;
	logic [dnle_pkg::IDX_W-1:0]      len_q;
	logic [dnle_pkg::BYTE_CNT_W-1:0] be_q;
	logic                            disc_q;
	logic                            bank_q;
	logic [dnle_pkg::BCNT_W-1:0]     body_cnt_q;

	logic                            acc;
	logic                            is_dot;
	logic                            is_end;
	logic                            len_full;
	logic [dnle_pkg::SUM_W-1:0]      lim17;
	logic [dnle_pkg::SUM_W-1:0]      be1;
	logic [dnle_pkg::SUM_W-1:0]      be_body;
	logic                            term_over;
	logic                            err;
	logic                            push;
	logic                            wr_en;
	logic [dnle_pkg::IDX_W-1:0]      len_n;
	logic [dnle_pkg::BYTE_CNT_W-1:0] be_n;
	logic                            disc_n;

	// config register always takes writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= dnle_pkg::BYTE_CNT_W'(512);
		end else if (cfg_valid) begin
			lim_q <= space_limit;
		end
	end

	// hold off when the queue is full or both store banks are held by the back
	assign in_stall = q_full || (body_cnt_q == dnle_pkg::BCNT_W'(dnle_pkg::BANKS));
	assign acc      = in_valid && !in_stall;

	// limit checks for length byte, body and terminator
	assign is_dot    = (char_code == dnle_pkg::CH_DOT);
	assign is_end    = (char_code == dnle_pkg::CH_END);
	assign len_full  = (len_q >= dnle_pkg::IDX_W'(dnle_pkg::LABEL_BYTES - 1));
	assign lim17     = {1'b0, lim_q};
	assign be1       = {1'b0, be_q} + dnle_pkg::SUM_W'(1);
	assign be_body   = be1 + dnle_pkg::SUM_W'(len_q);
	assign term_over = (len_q != '0) ? ((be_body + dnle_pkg::SUM_W'(1)) > lim17)
	                                 : (be1 > lim17);

	// item classification and next state
	always_comb begin
		cmd    = '0;
		push   = 1'b0;
		wr_en  = 1'b0;
		err    = 1'b0;
		len_n  = len_q;
		be_n   = be_q;
		disc_n = disc_q;
		if (disc_q) begin
			if (is_end) disc_n = 1'b0;
		end else if (!is_dot && !is_end) begin
			if (!len_full) begin
				wr_en = 1'b1;
				len_n = len_q + 1'b1;
			end else begin
				cmd.tail = dnle_pkg::TAIL_ERR2;
				err      = 1'b1;
			end
		end else begin
			cmd.len  = len_q;
			cmd.bank = bank_q;
			if (len_q != '0) begin
				if (be1 > lim17) begin
					cmd.tail = dnle_pkg::TAIL_ERR1;
					err      = 1'b1;
				end else begin
					cmd.emit_len = 1'b1;
					if (be_body > lim17) begin
						cmd.tail = dnle_pkg::TAIL_ERR1;
						err      = 1'b1;
					end else begin
						cmd.emit_body = 1'b1;
						be_n          = be_body[dnle_pkg::BYTE_CNT_W-1:0];
					end
				end
			end
			len_n = '0;
			if (!err && is_end) begin
				if (term_over) begin
					cmd.tail = dnle_pkg::TAIL_ERR1;
					err      = 1'b1;
				end else begin
					cmd.tail = dnle_pkg::TAIL_TERM;
					be_n     = '0;
				end
			end
		end
		if (err) begin
			len_n  = '0;
			be_n   = '0;
			disc_n = !is_end;
		end
		push = cmd.emit_len || (cmd.tail != dnle_pkg::TAIL_NONE);
	end

	assign cmd_push = acc && push;
	assign wr.en    = acc && wr_en;
	assign wr.addr  = {bank_q, len_q};
	assign wr.data  = char_code;

	// name state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			be_q   <= '0;
			disc_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (acc) begin
			len_q  <= len_n;
			be_q   <= be_n;
			disc_q <= disc_n;
			if (cmd_push && cmd.emit_body) bank_q <= !bank_q;
		end
	end

	// banks held by body commands not yet sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_cnt_q <= '0;
		end else begin
			if ((cmd_push && cmd.emit_body) && !body_done)
				body_cnt_q <= body_cnt_q + 1'b1;
			else if (!(cmd_push && cmd.emit_body) && body_done)
				body_cnt_q <= body_cnt_q - 1'b1;
		end
	end

	// never more bodies in flight than store banks
	a_body_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		body_cnt_q <= dnle_pkg::BCNT_W'(dnle_pkg::BANKS))
		else $error("body count above bank count");

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_full)
		else $error("command pushed into full queue");

	// character writes only while the current bank is free
	a_bank_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (body_cnt_q < dnle_pkg::BCNT_W'(dnle_pkg::BANKS)))
		else $error("store write into a bank still being sent");

endmodule

// ===== src/dnle_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_back
// Holds the two-bank label store and works through commands: length byte,
// label bytes read from the store, then terminator or error result, into a
// single output register.
// ----------------------------------------------------------------------------
module dnle_back (
	input  logic           clk,
	input  logic           arst_n,
	input  dnle_pkg::wr_t  wr,
	// command queue side
	input  logic           q_empty,
	input  dnle_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           body_done,
	// result item channel
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic [1:0]     status,
	output logic           run_last,
	output logic           name_done
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LEN  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_BODY = 3'd3;
	localparam logic [2:0] S_TAIL = 3'd4;

	logic [7:0]                 mem [2 * dnle_pkg::LABEL_BYTES];
	logic [7:0]                 rd_data_q;
	logic [2:0]                 state_q;
	dnle_pkg::cmd_t             cmd_q;
	logic [dnle_pkg::IDX_W-1:0] idx_q;

	logic                       slot_free;
	logic                       load;
	logic                       body_end;
	logic [7:0]                 ld_byte;
	logic [1:0]                 ld_status;
	logic                       ld_last;
	logic                       ld_done;

	logic                       out_v_q;
	logic [7:0]                 byte_q;
	logic [1:0]                 status_q;
	logic                       last_q;
	logic                       done_q;

	// label store, two banks
	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		if (state_q == S_RD) rd_data_q <= mem[{cmd_q.bank, idx_q}];
	end

	assign slot_free = !out_v_q || !out_stall;
	assign body_end  = (idx_q == (cmd_q.len - 1'b1));
	assign q_pop     = (state_q == S_IDLE) && !q_empty;

	// result selection for the current step
	always_comb begin
		load      = 1'b0;
		ld_byte   = '0;
		ld_status = dnle_pkg::ST_OK;
		ld_last   = 1'b0;
		ld_done   = 1'b0;
		case (state_q)
			S_LEN: begin
				load    = slot_free;
				ld_byte = {2'b00, 1'b0, cmd_q.len} & dnle_pkg::LEN_MASK;
			end
			S_BODY: begin
				load    = slot_free;
				ld_byte = rd_data_q;
				ld_last = body_end && (cmd_q.tail == dnle_pkg::TAIL_NONE);
			end
			S_TAIL: begin
				load    = slot_free;
				ld_last = 1'b1;
				ld_done = 1'b1;
				case (cmd_q.tail)
					dnle_pkg::TAIL_ERR1: ld_status = dnle_pkg::ST_SPACE;
					dnle_pkg::TAIL_ERR2: ld_status = dnle_pkg::ST_LONG;
					default:             ld_status = dnle_pkg::ST_OK;
				endcase
			end
			default: load = 1'b0;
		endcase
	end

	assign body_done = (state_q == S_BODY) && load && body_end;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						idx_q   <= '0;
						state_q <= q_head.emit_len ? S_LEN : S_TAIL;
					end
				end
				S_LEN: begin
					if (load) state_q <= cmd_q.emit_body ? S_RD : S_TAIL;
				end
				S_RD: begin
					state_q <= S_BODY;
				end
				S_BODY: begin
					if (load) begin
						if (body_end) begin
							state_q <= (cmd_q.tail != dnle_pkg::TAIL_NONE) ? S_TAIL : S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_TAIL: begin
					if (load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// current command
	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_head;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= ld_byte;
			status_q <= ld_status;
			last_q   <= ld_last;
			done_q   <= ld_done;
		end
	end

	assign out_valid = out_v_q;
	assign out_byte  = byte_q;
	assign status    = status_q;
	assign run_last  = last_q;
	assign name_done = done_q;

	// a finished name is always the last result of its item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_done |-> run_last)
		else $error("name done without run last");

	// error results carry a zero byte and finish the name
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != dnle_pkg::ST_OK) |-> (out_byte == 8'h00) && name_done)
		else $error("error result with data byte");

	// a store read is followed by the body step
	a_rd_body: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> (state_q == S_BODY))
		else $error("read step not followed by body step");

endmodule

// ===== src/dns_name_label_encoder_top.sv =====
// A separator or end item passes the command queue, the command load and the output register
// before its first result shows, when the back is idle. Characters are taken one per cycle
// unless in_stall holds them off (command queue full or both store banks held); the back
// loads each command, then sends the length byte, each label byte (store read, then output
// register) and the closing result. Reset clears all control state and sets the space limit
// to 512; the store is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_top
// DNS name label encoder: dotted name characters in, length-prefixed labels
// and a zero terminator out, with space-limit and label-length errors.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      char_code,
	// result items
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_byte,
	output logic [1:0]                      status,
	output logic                            run_last,
	output logic                            name_done,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dnle_pkg::BYTE_CNT_W-1:0] space_limit
);

	dnle_pkg::wr_t  wr;
	dnle_pkg::cmd_t cmd;
	dnle_pkg::cmd_t q_head;
	logic           cmd_push;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic           body_done;

	// classify and store
	dnle_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.space_limit (space_limit),
		.wr          (wr),
		.cmd_push    (cmd_push),
		.cmd         (cmd),
		.q_full      (q_full),
		.body_done   (body_done)
	);

	// command queue
	dnle_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// emit
	dnle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.body_done (body_done),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.status    (status),
		.run_last  (run_last),
		.name_done (name_done)
	);

endmodule

// ===== sim/tb_dns_name_label_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_name_label_encoder_top
// Self-checking bench for the DNS name label encoder. A directed table walks
// the edge cases first: empty names, the longest label, a label that is one
// character too long, and missing room for length, body and terminator. Random
// names with random content follow, over several space limits. Every result
// is checked against an in-bench encoder that tracks the label store, byte
// count and drop state. Both sides stall at random, and the receiver holds
// off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_dns_name_label_encoder_top;

	localparam int CLK_HALF   = 5;
	localparam int CYCLE_CAP  = 300000;
	localparam int IDLE_PCT   = 18;
	localparam int HOLD_LEN   = 300;
	localparam int SETTLE     = 10;
	localparam int PHASE_LEN  = 2;
	localparam int N_PHASES   = 6;

	typedef enum logic [1:0] {ROW_CHAR, ROW_RUN, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		int          value;
		bit          typed;
		logic [7:0]  want_byte;
		logic [1:0]  want_status;
	} dir_row_t;

	typedef struct {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       run_last;
		logic       name_done;
	} enc_result_t;

	// dut ports
	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            in_valid    = 1'b0;
	logic                            in_stall;
	logic [7:0]                      char_code   = 8'h00;
	logic                            out_valid;
	logic                            out_stall   = 1'b0;
	logic [7:0]                      out_byte;
	logic [1:0]                      status;
	logic                            run_last;
	logic                            name_done;
	logic                            cfg_valid   = 1'b0;
	logic                            cfg_ready;
	logic [dnle_pkg::BYTE_CNT_W-1:0] space_limit = 16'd512;

	// encoder shadow state
	logic [7:0]  label_mem [dnle_pkg::LABEL_BYTES];
	int          label_cnt  = 0;
	int          name_bytes = 0;
	int          room_limit = 512;
	bit          dropping   = 1'b0;

	// results of the item just accepted, and everything still to come out
	enc_result_t step_res [64];
	int          n_res;
	enc_result_t expected_bytes [$];

	dir_row_t    directed [$];

	// run bookkeeping
	bit          idle_on     = 1'b1;
	int          hold_req    = 0;
	int          hold_seen   = 0;
	int          hold_left   = 0;
	int          cycles      = 0;
	int          mismatches  = 0;
	int          items_sent  = 0;
	int          names_sent  = 0;
	int          results_ok  = 0;
	int          space_errs  = 0;
	int          long_errs   = 0;

	dns_name_label_encoder_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.status     (status),
		.run_last   (run_last),
		.name_done  (name_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.space_limit(space_limit)
	);

	// clock
	always #CLK_HALF clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("%0t: timeout, %0d results still expected", $time, expected_bytes.size());
			$display("tb_dns_name_label_encoder_top failed");
			$finish;
		end
	end

	// receiver stall: random, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		enc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected result byte %0h status %0d", $time, out_byte, status);
				mismatches++;
			end else begin
				want = expected_bytes.pop_front();
				results_ok++;
				if (out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %0h actual %0h", $time, want.out_byte,
						out_byte);
					mismatches++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					mismatches++;
				end
				if (run_last !== want.run_last) begin
					$display("%0t: run_last expected %0b actual %0b", $time, want.run_last,
						run_last);
					mismatches++;
				end
				if (name_done !== want.name_done) begin
					$display("%0t: name_done expected %0b actual %0b", $time, want.name_done,
						name_done);
					mismatches++;
				end
			end
		end
	end

	// queue one result of the current item
	function automatic void stage(logic [7:0] b, logic [1:0] st, logic done);
		step_res[n_res].out_byte  = b;
		step_res[n_res].status    = st;
		step_res[n_res].run_last  = 1'b0;
		step_res[n_res].name_done = done;
		if (st == dnle_pkg::ST_SPACE)
			space_errs++;
		if (st == dnle_pkg::ST_LONG)
			long_errs++;
		n_res++;
	endfunction

	// encoder behavior for one accepted character
	task automatic predict_encoding(input logic [7:0] c);
		int  len;
		bit  err;
		n_res = 0;
		err   = 1'b0;
		if (dropping) begin
			if (c == dnle_pkg::CH_END)
				dropping = 1'b0;
			return;
		end
		if (c != dnle_pkg::CH_DOT && c != dnle_pkg::CH_END) begin
			// plain character: store it, or fail on an overlong label
			if (label_cnt + 1 < dnle_pkg::LABEL_BYTES) begin
				label_mem[label_cnt] = c;
				label_cnt++;
				return;
			end
			stage(8'h00, dnle_pkg::ST_LONG, 1'b1);
			err = 1'b1;
		end else begin
			// close the label: length byte, then body if it fits
			len = label_cnt;
			if (len != 0) begin
				if (name_bytes + 1 > room_limit) begin
					stage(8'h00, dnle_pkg::ST_SPACE, 1'b1);
					err = 1'b1;
				end else begin
					stage(len[7:0] & dnle_pkg::LEN_MASK, dnle_pkg::ST_OK, 1'b0);
					name_bytes += 1;
					if (name_bytes + len > room_limit) begin
						stage(8'h00, dnle_pkg::ST_SPACE, 1'b1);
						err = 1'b1;
					end else begin
						for (int i = 0; i < len; i++)
							stage(label_mem[i], dnle_pkg::ST_OK, 1'b0);
						name_bytes += len;
					end
				end
			end
			label_cnt = 0;
			// terminator on end of name
			if (!err && c == dnle_pkg::CH_END) begin
				if (name_bytes + 1 > room_limit) begin
					stage(8'h00, dnle_pkg::ST_SPACE, 1'b1);
					err = 1'b1;
				end else begin
					stage(dnle_pkg::CH_END, dnle_pkg::ST_OK, 1'b1);
					name_bytes = 0;
				end
			end
		end
		if (err) begin
			label_cnt  = 0;
			name_bytes = 0;
			if (c != dnle_pkg::CH_END)
				dropping = 1'b1;
		end
	endtask

	// offer one item, wait for it to be taken, then record what it should cause
	task automatic send_char(input logic [7:0] c, input bit typed, input logic [7:0] t_byte,
		input logic [1:0] t_status);
		enc_result_t r;
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		if (c == dnle_pkg::CH_END)
			names_sent++;
		predict_encoding(c);
		if (typed) begin
			r.out_byte  = t_byte;
			r.status    = t_status;
			r.run_last  = 1'b1;
			r.name_done = 1'b1;
			expected_bytes.push_back(r);
		end else begin
			for (int i = 0; i < n_res; i++) begin
				r          = step_res[i];
				r.run_last = (i == n_res - 1);
				expected_bytes.push_back(r);
			end
		end
	endtask

	task automatic send_plain(input logic [7:0] c);
		send_char(c, 1'b0, 8'h00, dnle_pkg::ST_OK);
	endtask

	// any character that is neither a separator nor the end
	function automatic logic [7:0] pick_label_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == dnle_pkg::CH_DOT);
		return c;
	endfunction

	// new space limit, written only once the block has drained
	task automatic write_limit(input int v);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid   <= 1'b1;
		space_limit <= v[15:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		room_limit = v & 16'hffff;
	endtask

	// a well-formed name with random labels, now and then broken or noisy
	task automatic send_random_name();
		int n_labels;
		int len;
		int pick;
		if ($urandom_range(0, 99) < 10) begin
			repeat ($urandom_range(1, 6))
				send_plain(8'($urandom_range(0, 255)));
			return;
		end
		n_labels = $urandom_range(1, 3);
		for (int l = 0; l < n_labels; l++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				len = 0;
			else if (pick < 12)
				len = $urandom_range(dnle_pkg::LABEL_BYTES - 1, dnle_pkg::LABEL_BYTES);
			else
				len = $urandom_range(1, 4);
			repeat (len)
				send_plain(pick_label_char());
			if (l != n_labels - 1 || $urandom_range(0, 99) < 8)
				send_plain(dnle_pkg::CH_DOT);
		end
		send_plain(dnle_pkg::CH_END);
	endtask

	function automatic dir_row_t step_row(row_kind_t k, int v, bit typed, logic [7:0] b,
		logic [1:0] st);
		dir_row_t r;
		r.kind        = k;
		r.value       = v;
		r.typed       = typed;
		r.want_byte   = b;
		r.want_status = st;
		return r;
	endfunction

	// stimulus
	initial begin
		int phase_end;
		dir_row_t row;

		// empty name straight after reset
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 1, 8'h00, dnle_pkg::ST_OK));
		// one label with all-ones and low characters, then an empty label
		directed.push_back(step_row(ROW_CHAR, 'h61, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'hff, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'h01, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_DOT), 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_DOT), 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'h80, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'h7f, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 0, 8'h00, dnle_pkg::ST_OK));
		// label one character too long, then dropped items up to the end
		directed.push_back(step_row(ROW_RUN, dnle_pkg::LABEL_BYTES - 1, 0, 8'h00,
			dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'h41, 1, 8'h00, dnle_pkg::ST_LONG));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_DOT), 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 0, 8'h00, dnle_pkg::ST_OK));
		// longest label that fits
		directed.push_back(step_row(ROW_RUN, dnle_pkg::LABEL_BYTES - 1, 0, 8'h00,
			dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 0, 8'h00, dnle_pkg::ST_OK));
		// no room at all: terminator, then length byte
		directed.push_back(step_row(ROW_CFG, 0, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 1, 8'h00,
			dnle_pkg::ST_SPACE));
		directed.push_back(step_row(ROW_CHAR, 'h62, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_DOT), 1, 8'h00,
			dnle_pkg::ST_SPACE));
		directed.push_back(step_row(ROW_CHAR, 'h63, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 0, 8'h00, dnle_pkg::ST_OK));
		// room for the length byte but not the body
		directed.push_back(step_row(ROW_CFG, 3, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'h61, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'h62, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'h63, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_DOT), 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 0, 8'h00, dnle_pkg::ST_OK));
		// body fits, terminator does not; the next name starts clean
		directed.push_back(step_row(ROW_CFG, 2, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'h61, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 1, 8'h00, dnle_pkg::ST_OK));
		// widest limit, then back to the reset value
		directed.push_back(step_row(ROW_CFG, 65535, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, 'h78, 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CHAR, int'(dnle_pkg::CH_END), 0, 8'h00, dnle_pkg::ST_OK));
		directed.push_back(step_row(ROW_CFG, 512, 0, 8'h00, dnle_pkg::ST_OK));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed[i]) begin
			row = directed[i];
			case (row.kind)
				ROW_CHAR: begin
					send_char(row.value[7:0], row.typed, row.want_byte, row.want_status);
				end
				ROW_RUN: begin
					repeat (row.value)
						send_plain(pick_label_char());
				end
				ROW_CFG: begin
					write_limit(row.value);
				end
				default: begin
				end
			endcase
		end

		// random names over several limits
		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				1:       write_limit($urandom_range(0, 24));
				2:       write_limit(65535);
				3:       write_limit($urandom_range(8, 60));
				4:       write_limit(512);
				5:       write_limit($urandom_range(0, 12));
				default: begin
				end
			endcase
			// one phase runs without any idling on either side
			idle_on = (phase != 2);
			// receiver holds off while short labels keep coming
			if (phase == 4) begin
				hold_req++;
				repeat (6) begin
					send_plain(8'h61);
					send_plain(dnle_pkg::CH_DOT);
				end
				send_plain(dnle_pkg::CH_END);
			end
			phase_end = items_sent + PHASE_LEN;
			while (items_sent < phase_end)
				send_random_name();
		end

		// drain
		in_valid <= 1'b0;
		idle_on = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d items in %0d names, %0d results checked", items_sent,
			names_sent, results_ok);
		$display("errors seen: %0d out of space, %0d label too long", space_errs, long_errs);
		if (mismatches == 0) begin
			$display("tb_dns_name_label_encoder_top passed");
		end else begin
			$display("tb_dns_name_label_encoder_top failed");
		end
		$finish;
	end

endmodule

// ===== dns_name_label_encoder_top.f =====
src/dnle_pkg.sv
src/dnle_cmdq.sv
src/dnle_front.sv
src/dnle_back.sv
src/dns_name_label_encoder_top.sv
sim/tb_dns_name_label_encoder_top.sv
